// ===== sv/rshs_pkg.sv =====
// ----------------------------------------------------------------------------
// rshs_pkg: shared types and codes for the rotary stepper homing/steering unit
// Field widths, command codes, homing phase codes and register indexes.
// ----------------------------------------------------------------------------
package rshs_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned OffW   = 11;
  localparam int unsigned WinW   = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic [PosW-1:0]   pos_t;
  typedef logic [CmdW-1:0]   cmd_t;
  typedef logic [ModeW-1:0]  mode_t;
  typedef logic [PhaseW-1:0] phase_t;

  // commands
  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_HOME   = 2'd1;
  localparam cmd_t CMD_TARGET = 2'd2;
  localparam cmd_t CMD_MODE   = 2'd3;

  // auto-rotate modes (code 3 is stored but acts as none)
  localparam mode_t ROT_NONE = 2'd0;
  localparam mode_t ROT_UP   = 2'd1;
  localparam mode_t ROT_DOWN = 2'd2;

  // homing phases
  localparam phase_t PH_START = 4'd0;
  localparam phase_t PH_SEEK1 = 4'd1;
  localparam phase_t PH_SEEK2 = 4'd2;
  localparam phase_t PH_SEEK3 = 4'd3;
  localparam phase_t PH_SEEK4 = 4'd4;
  localparam phase_t PH_DONE  = 4'd5;
  localparam phase_t PH_FAIL1 = 4'd6;
  localparam phase_t PH_FAIL2 = 4'd7;
  localparam phase_t PH_FAIL3 = 4'd8;
  localparam phase_t PH_FAIL4 = 4'd9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SWEEP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW   = 3'd5;

  // register reset values
  localparam pos_t             RST_SWEEP    = 16'd5370;
  localparam pos_t             RST_CENTER   = 16'd2685;
  localparam pos_t             RST_INTERVAL = 16'd2000;
  localparam pos_t             RST_LIMIT    = 16'd8000;
  localparam logic [OffW-1:0]  RST_OFFSET   = 11'd40;
  localparam logic [WinW-1:0]  RST_WINDOW   = 10'd30;

  // one input item as held in the input register
  typedef struct packed {
    cmd_t  cmd;
    logic  hall_down;
    pos_t  target_position;
    mode_t rotate_mode;
  } in_item_t;

endpackage

// ===== sv/rshs_in_if.sv =====
// ----------------------------------------------------------------------------
// rshs_in_if: input item channel
// Valid/ready handshake carrying one tick or command.
// ----------------------------------------------------------------------------
interface rshs_in_if;
  logic                 valid;
  logic                 ready;
  rshs_pkg::cmd_t       cmd;
  logic                 hall_down;
  rshs_pkg::pos_t       target_position;
  rshs_pkg::mode_t      rotate_mode;

  modport source (output valid, output cmd, output hall_down,
                  output target_position, output rotate_mode, input ready);
  modport sink   (input valid, input cmd, input hall_down,
                  input target_position, input rotate_mode, output ready);
endinterface

// ===== sv/rshs_out_if.sv =====
// ----------------------------------------------------------------------------
// rshs_out_if: result item channel
// Valid/ready handshake carrying step command and homing status.
// ----------------------------------------------------------------------------
interface rshs_out_if;
  logic                 valid;
  logic                 ready;
  logic                 step_pulse;
  logic                 step_dir;
  rshs_pkg::pos_t       position;
  rshs_pkg::phase_t     homing_phase;
  logic                 homed;

  modport source (output valid, output step_pulse, output step_dir,
                  output position, output homing_phase, output homed, input ready);
  modport sink   (input valid, input step_pulse, input step_dir,
                  input position, input homing_phase, input homed, output ready);
endinterface

// ===== sv/rotary_stepper_homing_and_steering_unit.sv =====
// ----------------------------------------------------------------------------
// rotary_stepper_homing_and_steering_unit: stepper homing and ring steering
// Paces ticks with a step-rate timer, runs a four-phase hall-sensor homing
// sequence, then steps along the shorter arc of the position ring.
// ----------------------------------------------------------------------------
// Path: input register, then result register; a result-side stall holds the item in the input register.
// Throughput: 1 item per cycle unless the result side stalls; the state update is a single pass of compares
//   and 16- to 18-bit adds between the input register and the result register.
// Reset (rst_n low, synchronous): both pipeline stages empty, homing phase 0,
//   counters/positions/auto mode cleared, config registers to defaults.
module rotary_stepper_homing_and_steering_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  rshs_in_if.sink                        in_ch,
  rshs_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rshs_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [rshs_pkg::CfgDataW-1:0]  cfg_wdata
);

  // --------------------------------------------------------------------------
  // Ring helpers
  // --------------------------------------------------------------------------
  // One step on the ring 0..sweep-1; out-of-ring positions wrap as well.
  function automatic rshs_pkg::pos_t ring_move(input rshs_pkg::pos_t cur,
                                               input logic up,
                                               input rshs_pkg::pos_t sweep);
    logic [16:0] v;
    v = '0;
    if (sweep == '0) begin
      return '0;
    end
    if (up) begin
      v = {1'b0, cur} + 17'd1;
    end else if (cur == '0) begin
      v = {1'b0, sweep} - 17'd1;
    end else begin
      v = {1'b0, cur} - 17'd1;
    end
    if (v >= {1'b0, sweep}) begin
      v = '0;
    end
    return v[15:0];
  endfunction

  // Shorter-arc direction; a negative arc length behaves as a huge unsigned one.
  function automatic logic go_up(input rshs_pkg::pos_t cur,
                                 input rshs_pkg::pos_t goal,
                                 input rshs_pkg::pos_t sweep);
    logic signed [17:0] up_len;
    logic signed [17:0] dn_len;
    up_len = '0;
    dn_len = '0;
    if (cur < goal) begin
      up_len = $signed({2'b00, goal}) - $signed({2'b00, cur});
      dn_len = $signed({2'b00, cur}) + $signed({2'b00, sweep})
             - $signed({2'b00, goal});
      return !((dn_len >= 18'sd0) && (dn_len < up_len));
    end else begin
      up_len = $signed({2'b00, goal}) + $signed({2'b00, sweep})
             - $signed({2'b00, cur});
      dn_len = $signed({2'b00, cur}) - $signed({2'b00, goal});
      return !((up_len < 18'sd0) || (dn_len < up_len));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  rshs_pkg::pos_t                 sweep_r, center_r, interval_r, limit_r;
  logic [rshs_pkg::OffW-1:0]      offset_r;
  logic [rshs_pkg::WinW-1:0]      window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r    <= rshs_pkg::RST_SWEEP;
      center_r   <= rshs_pkg::RST_CENTER;
      interval_r <= rshs_pkg::RST_INTERVAL;
      limit_r    <= rshs_pkg::RST_LIMIT;
      offset_r   <= rshs_pkg::RST_OFFSET;
      window_r   <= rshs_pkg::RST_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rshs_pkg::CFG_SWEEP:    sweep_r    <= cfg_wdata;
        rshs_pkg::CFG_CENTER:   center_r   <= cfg_wdata;
        rshs_pkg::CFG_INTERVAL: interval_r <= cfg_wdata;
        rshs_pkg::CFG_LIMIT:    limit_r    <= cfg_wdata;
        rshs_pkg::CFG_OFFSET:   offset_r   <= cfg_wdata[rshs_pkg::OffW-1:0];
        rshs_pkg::CFG_WINDOW:   window_r   <= cfg_wdata[rshs_pkg::WinW-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: input register -> result register
  // --------------------------------------------------------------------------
  logic                 in_vld_r;
  rshs_pkg::in_item_t   item_r;
  logic                 out_vld_r;
  logic                 fire;      // item in input reg is processed this cycle

  assign fire         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || fire;
  assign out_ch.valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.cmd             <= in_ch.cmd;
      item_r.hall_down       <= in_ch.hall_down;
      item_r.target_position <= in_ch.target_position;
      item_r.rotate_mode     <= in_ch.rotate_mode;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  rshs_pkg::phase_t  phase_r, phase_nxt;
  rshs_pkg::pos_t    count_r, count_nxt;
  rshs_pkg::pos_t    pos_r, pos_nxt;
  rshs_pkg::pos_t    goal_r, goal_nxt;
  rshs_pkg::pos_t    ticks_r, ticks_nxt;
  logic              first_r, first_nxt;
  rshs_pkg::mode_t   auto_r, auto_nxt;
  logic              pulse, dir;

  // shared terms
  rshs_pkg::pos_t    ticks_inc, count_inc, sweep_top, target_clamped;
  rshs_pkg::pos_t    pos_up, pos_dn, auto_goal, steer_pos, home_pos;
  logic              steer_up, over_limit, past_window;

  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + 16'd1;   // saturating
  assign count_inc = (count_r == '1) ? count_r : count_r + 16'd1;
  assign over_limit  = count_r > limit_r;
  assign past_window = count_r > {6'd0, window_r};

  assign sweep_top      = (sweep_r == '0) ? '0 : sweep_r - 16'd1;
  assign target_clamped = (item_r.target_position > sweep_top) ? sweep_top
                                                               : item_r.target_position;

  // steering: auto-rotate places the goal next to the current position
  assign pos_up    = ring_move(pos_r, 1'b1, sweep_r);
  assign pos_dn    = ring_move(pos_r, 1'b0, sweep_r);
  assign auto_goal = (auto_r == rshs_pkg::ROT_UP)   ? pos_up :
                     (auto_r == rshs_pkg::ROT_DOWN) ? pos_dn : goal_r;
  assign steer_up  = go_up(pos_r, auto_goal, sweep_r);
  assign steer_pos = steer_up ? pos_up : pos_dn;

  // home = center - count/2 + signed offset, modulo 2^16
  assign home_pos = center_r - {1'b0, count_r[15:1]}
                  + {{(rshs_pkg::PosW-rshs_pkg::OffW){offset_r[rshs_pkg::OffW-1]}},
                     offset_r};

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    goal_nxt  = goal_r;
    ticks_nxt = ticks_r;
    first_nxt = first_r;
    auto_nxt  = auto_r;
    pulse     = 1'b0;
    dir       = 1'b0;
    unique case (item_r.cmd)
      rshs_pkg::CMD_HOME:   phase_nxt = rshs_pkg::PH_START;
      rshs_pkg::CMD_TARGET: goal_nxt  = target_clamped;
      rshs_pkg::CMD_MODE:   auto_nxt  = item_r.rotate_mode;
      rshs_pkg::CMD_TICK: begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= interval_r) begin
          if (phase_r != rshs_pkg::PH_DONE) begin
            // every homing action, failure phases included, restarts the timer
            ticks_nxt = '0;
            unique case (phase_r)
              rshs_pkg::PH_START: begin
                count_nxt = '0;
                phase_nxt = rshs_pkg::PH_SEEK1;
              end
              rshs_pkg::PH_SEEK1: begin
                // step up until the magnet is found
                if (item_r.hall_down) begin
                  phase_nxt = rshs_pkg::PH_SEEK2;
                end else begin
                  if (over_limit) phase_nxt = rshs_pkg::PH_FAIL1;
                  pulse     = 1'b1;
                  dir       = 1'b1;
                  count_nxt = count_inc;
                end
              end
              rshs_pkg::PH_SEEK2: begin
                // step up until the magnet is left
                if (!item_r.hall_down) begin
                  phase_nxt = rshs_pkg::PH_SEEK3;
                  count_nxt = '0;
                end else begin
                  if (over_limit) phase_nxt = rshs_pkg::PH_FAIL2;
                  pulse     = 1'b1;
                  dir       = 1'b1;
                  count_nxt = count_inc;
                end
              end
              rshs_pkg::PH_SEEK3: begin
                // step down until the magnet is found again
                if (item_r.hall_down) begin
                  phase_nxt = rshs_pkg::PH_SEEK4;
                end else begin
                  if (over_limit) phase_nxt = rshs_pkg::PH_FAIL3;
                  pulse     = 1'b1;
                  count_nxt = count_inc;
                end
              end
              rshs_pkg::PH_SEEK4: begin
                // step down across the window; exit only past the minimum width
                if (!item_r.hall_down && past_window) begin
                  phase_nxt = rshs_pkg::PH_DONE;
                  pos_nxt   = home_pos;
                  if (!first_r) begin
                    goal_nxt  = center_r;
                    first_nxt = 1'b1;
                  end
                end else begin
                  if (over_limit) phase_nxt = rshs_pkg::PH_FAIL4;
                  pulse     = 1'b1;
                  count_nxt = count_inc;
                end
              end
              default: ;  // failure phases wait for a homing command
            endcase
          end else begin
            goal_nxt = auto_goal;
            if (pos_r != auto_goal) begin
              pulse     = 1'b1;
              dir       = steer_up;
              pos_nxt   = steer_pos;
              ticks_nxt = '0;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rshs_pkg::PH_START;
      count_r <= '0;
      pos_r   <= '0;
      goal_r  <= '0;
      ticks_r <= '0;
      first_r <= 1'b0;
      auto_r  <= rshs_pkg::ROT_NONE;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      goal_r  <= goal_nxt;
      ticks_r <= ticks_nxt;
      first_r <= first_nxt;
      auto_r  <= auto_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              res_pulse_r, res_dir_r, res_homed_r;
  rshs_pkg::pos_t    res_pos_r;
  rshs_pkg::phase_t  res_phase_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      res_pulse_r <= pulse;
      res_dir_r   <= pulse & dir;
      res_pos_r   <= pos_nxt;
      res_phase_r <= phase_nxt;
      res_homed_r <= (phase_nxt == rshs_pkg::PH_DONE);
    end
  end

  assign out_ch.step_pulse   = res_pulse_r;
  assign out_ch.step_dir     = res_dir_r;
  assign out_ch.position     = res_pos_r;
  assign out_ch.homing_phase = res_phase_r;
  assign out_ch.homed        = res_homed_r;

endmodule

// ===== sim/tb_rotary_stepper_homing_and_steering_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_stepper_homing_and_steering_unit: self-checking bench
// A directed table covers reset state, homing to completion, steering, auto
// rotate and a limit failure. Randomized runs then follow under several
// register settings. Every result item is checked against its hand-typed
// result or an in-bench predictor of the homing/steering state.
// ----------------------------------------------------------------------------
module tb_rotary_stepper_homing_and_steering_unit;

  // Result is registered twice behind the input
  localparam int unsigned PIPE_LATENCY    = 2;
  localparam int unsigned SETTLE_CYCLES   = PIPE_LATENCY + 2;
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int unsigned RUN_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned MAX_IDLE        = 17;

  // One result item as the bench sees it
  typedef struct packed {
    logic             pulse;
    logic             dir;
    rshs_pkg::pos_t   pos;
    rshs_pkg::phase_t phase;
    logic             homed;
  } report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an input item or a register write,
  // with an optional hand-typed result
  typedef struct packed {
    row_kind_t                       kind;
    rshs_pkg::in_item_t              item;
    logic [rshs_pkg::CfgIdxW-1:0]    cfg_idx;
    logic [rshs_pkg::CfgDataW-1:0]   cfg_val;
    logic                            typed;
    report_t                         want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                          cfg_we;
  logic [rshs_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [rshs_pkg::CfgDataW-1:0] cfg_wdata;

  rshs_in_if  in_ch ();
  rshs_out_if out_ch ();

  rotary_stepper_homing_and_steering_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers plus the homing/steering state
  // --------------------------------------------------------------------------
  rshs_pkg::pos_t            sh_sweep, sh_center, sh_interval, sh_limit;
  logic [rshs_pkg::OffW-1:0] sh_offset;
  logic [rshs_pkg::WinW-1:0] sh_window;

  rshs_pkg::phase_t hm_phase;
  rshs_pkg::pos_t   hm_count;
  rshs_pkg::pos_t   track_pos;
  rshs_pkg::pos_t   goal_pos;
  rshs_pkg::pos_t   tick_count;
  logic             homed_once;
  rshs_pkg::mode_t  spin_mode;

  report_t expected_reports [$];
  int      mismatches = 0;
  int unsigned cycles = 0;

  // Stall knobs; some phases run with no idling at all
  bit quiet_sender   = 1'b0;
  bit quiet_receiver = 1'b0;

  plan_row_t plan [$];

  // Neighbor on the ring; anything at or past the end wraps to 0
  function automatic rshs_pkg::pos_t ring_step(rshs_pkg::pos_t cur, bit up);
    int v;
    v = int'(cur) + (up ? 1 : -1);
    if (sh_sweep == '0) return '0;
    if (v < 0) v = int'(sh_sweep) - 1;
    if (v >= int'(sh_sweep)) v = 0;
    return rshs_pkg::pos_t'(v);
  endfunction

  // Shorter arc, ties go up. Arc lengths wrap at 32 bits when the position
  // sits outside the ring, same as the block.
  function automatic bit arc_goes_up(rshs_pkg::pos_t cur, rshs_pkg::pos_t goal);
    logic [31:0] up_len, down_len;
    if (cur < goal) begin
      up_len   = 32'(goal) - 32'(cur);
      down_len = 32'(cur) + 32'(sh_sweep) - 32'(goal);
    end else begin
      up_len   = 32'(goal) + 32'(sh_sweep) - 32'(cur);
      down_len = 32'(cur) - 32'(goal);
    end
    return !(down_len < up_len);
  endfunction

  function automatic void bump_count();
    if (hm_count != 16'hFFFF) hm_count = hm_count + 1'b1;
  endfunction

  // Applies one accepted item to the predicted state, returns its result
  function automatic report_t advance_stepper(rshs_pkg::in_item_t it);
    report_t          r;
    rshs_pkg::pos_t   top;
    rshs_pkg::pos_t   off16;
    rshs_pkg::phase_t was;
    bit               up;
    r = '0;
    unique case (it.cmd)
      rshs_pkg::CMD_HOME: hm_phase = rshs_pkg::PH_START;
      rshs_pkg::CMD_TARGET: begin
        top = (sh_sweep != '0) ? sh_sweep - 1'b1 : '0;
        goal_pos = (it.target_position > top) ? top : it.target_position;
      end
      rshs_pkg::CMD_MODE: spin_mode = it.rotate_mode;
      default: begin
        if (tick_count != 16'hFFFF) tick_count = tick_count + 1'b1;
        if (tick_count >= sh_interval) begin
          if (hm_phase != rshs_pkg::PH_DONE) begin
            // every homing action restarts the rate timer, failures too
            tick_count = '0;
            was = hm_phase;
            unique case (hm_phase)
              rshs_pkg::PH_START: begin
                hm_count = '0;
                hm_phase = rshs_pkg::PH_SEEK1;
              end
              rshs_pkg::PH_SEEK1, rshs_pkg::PH_SEEK3: begin
                if (it.hall_down) begin
                  hm_phase = (was == rshs_pkg::PH_SEEK1) ? rshs_pkg::PH_SEEK2
                                                         : rshs_pkg::PH_SEEK4;
                end else begin
                  // over the limit: fail, but this step still goes out
                  if (hm_count > sh_limit)
                    hm_phase = (was == rshs_pkg::PH_SEEK1) ? rshs_pkg::PH_FAIL1
                                                           : rshs_pkg::PH_FAIL3;
                  r.pulse = 1'b1;
                  r.dir   = (was == rshs_pkg::PH_SEEK1);
                  bump_count();
                end
              end
              rshs_pkg::PH_SEEK2: begin
                if (!it.hall_down) begin
                  hm_phase = rshs_pkg::PH_SEEK3;
                  hm_count = '0;
                end else begin
                  if (hm_count > sh_limit) hm_phase = rshs_pkg::PH_FAIL2;
                  r.pulse = 1'b1;
                  r.dir   = 1'b1;
                  bump_count();
                end
              end
              rshs_pkg::PH_SEEK4: begin
                if (!it.hall_down && hm_count > sh_window) begin
                  // home value is mod 2^16, not folded into the ring
                  off16 = {{(rshs_pkg::PosW-rshs_pkg::OffW){sh_offset[rshs_pkg::OffW-1]}},
                           sh_offset};
                  hm_phase  = rshs_pkg::PH_DONE;
                  track_pos = sh_center - (hm_count >> 1) + off16;
                  if (!homed_once) begin
                    goal_pos   = sh_center;
                    homed_once = 1'b1;
                  end
                end else begin
                  if (hm_count > sh_limit) hm_phase = rshs_pkg::PH_FAIL4;
                  r.pulse = 1'b1;
                  r.dir   = 1'b0;
                  bump_count();
                end
              end
              default: ;  // failure phases wait for a homing command
            endcase
          end else begin
            if (spin_mode == rshs_pkg::ROT_UP) goal_pos = ring_step(track_pos, 1'b1);
            else if (spin_mode == rshs_pkg::ROT_DOWN) goal_pos = ring_step(track_pos, 1'b0);
            // steering only restarts the timer when it actually steps
            if (track_pos != goal_pos) begin
              up         = arc_goes_up(track_pos, goal_pos);
              r.pulse    = 1'b1;
              r.dir      = up;
              track_pos  = ring_step(track_pos, up);
              tick_count = '0;
            end
          end
        end
      end
    endcase
    r.pos   = track_pos;
    r.phase = hm_phase;
    r.homed = (hm_phase == rshs_pkg::PH_DONE);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic plan_row_t item_row(rshs_pkg::cmd_t c, logic h, rshs_pkg::pos_t t,
                                         rshs_pkg::mode_t m);
    plan_row_t r;
    r = '0;
    r.kind                 = ROW_ITEM;
    r.item.cmd             = c;
    r.item.hall_down       = h;
    r.item.target_position = t;
    r.item.rotate_mode     = m;
    return r;
  endfunction

  function automatic plan_row_t checked_row(rshs_pkg::cmd_t c, logic h, rshs_pkg::pos_t t,
                                            rshs_pkg::mode_t m, logic pulse, logic dir,
                                            rshs_pkg::pos_t pos, rshs_pkg::phase_t ph);
    plan_row_t r;
    r       = item_row(c, h, t, m);
    r.typed = 1'b1;
    r.want  = '{pulse: pulse, dir: dir, pos: pos, phase: ph,
                homed: (ph == rshs_pkg::PH_DONE)};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [rshs_pkg::CfgIdxW-1:0] idx,
                                        logic [rshs_pkg::CfgDataW-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Register write while idle; the extra edge keeps we from being lowered
  // and raised in the same step on back-to-back writes
  task automatic write_reg(logic [rshs_pkg::CfgIdxW-1:0] idx,
                           logic [rshs_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      rshs_pkg::CFG_SWEEP:    sh_sweep    = val;
      rshs_pkg::CFG_CENTER:   sh_center   = val;
      rshs_pkg::CFG_INTERVAL: sh_interval = val;
      rshs_pkg::CFG_LIMIT:    sh_limit    = val;
      rshs_pkg::CFG_OFFSET:   sh_offset   = val[rshs_pkg::OffW-1:0];
      rshs_pkg::CFG_WINDOW:   sh_window   = val[rshs_pkg::WinW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item after a random gap; predict once it is taken
  task automatic send_item(rshs_pkg::in_item_t it, logic typed, report_t want);
    int unsigned gap;
    report_t     predicted;
    gap = quiet_sender ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.cmd             <= it.cmd;
    in_ch.hall_down       <= it.hall_down;
    in_ch.target_position <= it.target_position;
    in_ch.rotate_mode     <= it.rotate_mode;
    in_ch.valid           <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predicted = advance_stepper(it);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every predicted result has been seen
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, compare each taken item with the oldest
  // prediction
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    report_t     want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = quiet_receiver ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      if (expected_reports.size() == 0) begin
        $error("result item with none expected: position %0d phase %0d",
               out_ch.position, out_ch.homing_phase);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("step_pulse",   want.pulse, out_ch.step_pulse);
        check_field("step_dir",     want.dir,   out_ch.step_dir);
        check_field("position",     want.pos,   out_ch.position);
        check_field("homing_phase", want.phase, out_ch.homing_phase);
        check_field("homed",        want.homed, out_ch.homed);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rshs_pkg::in_item_t        it;
    rshs_pkg::pos_t            sw, ctr, ivl, lim;
    logic [rshs_pkg::OffW-1:0] off;
    logic [rshs_pkg::WinW-1:0] win;
    rshs_pkg::phase_t          seen_ph;
    int unsigned               seek_ticks, dwell, roll;
    bit                        seeking;

    // every block input known from time 0
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= rshs_pkg::CFG_SWEEP;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= rshs_pkg::CMD_TICK;
    in_ch.hall_down       <= 1'b0;
    in_ch.target_position <= '0;
    in_ch.rotate_mode     <= rshs_pkg::ROT_NONE;

    sh_sweep    = rshs_pkg::RST_SWEEP;
    sh_center   = rshs_pkg::RST_CENTER;
    sh_interval = rshs_pkg::RST_INTERVAL;
    sh_limit    = rshs_pkg::RST_LIMIT;
    sh_offset   = rshs_pkg::RST_OFFSET;
    sh_window   = rshs_pkg::RST_WINDOW;
    hm_phase    = rshs_pkg::PH_START;
    hm_count    = '0;
    track_pos   = '0;
    goal_pos    = '0;
    tick_count  = '0;
    homed_once  = 1'b0;
    spin_mode   = rshs_pkg::ROT_NONE;
    seen_ph     = rshs_pkg::PH_FAIL4;
    seek_ticks  = 0;
    dwell       = 0;

    // Directed walk. Defaults: 5370-step ring, center 2685, offset +40,
    // interval 2000, so the very first tick just counts.
    plan = {
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd0, rshs_pkg::PH_START),
      // target above the ring clamps to its last position
      checked_row(rshs_pkg::CMD_TARGET, 1'b1, 16'hFFFF, rshs_pkg::ROT_DOWN,
                  0, 0, 16'd0, rshs_pkg::PH_START),
      // mode code 3 is kept but behaves as no rotation
      checked_row(rshs_pkg::CMD_MODE, 1'b1, 16'hFFFF, 2'd3,
                  0, 0, 16'd0, rshs_pkg::PH_START),
      cfg_row(rshs_pkg::CFG_INTERVAL, 16'd1),
      cfg_row(rshs_pkg::CFG_WINDOW,   16'd0),
      // full homing: up to the sensor, through it, back down, out the far side
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd0, rshs_pkg::PH_SEEK1),
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  1, 1, 16'd0, rshs_pkg::PH_SEEK1),
      checked_row(rshs_pkg::CMD_TICK, 1'b1, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd0, rshs_pkg::PH_SEEK2),
      checked_row(rshs_pkg::CMD_TICK, 1'b1, 16'd0, rshs_pkg::ROT_NONE,
                  1, 1, 16'd0, rshs_pkg::PH_SEEK2),
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd0, rshs_pkg::PH_SEEK3),
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  1, 0, 16'd0, rshs_pkg::PH_SEEK3),
      checked_row(rshs_pkg::CMD_TICK, 1'b1, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd0, rshs_pkg::PH_SEEK4),
      // first completion: home at center - 0 + 40, goal snaps to center
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd2725, rshs_pkg::PH_DONE),
      item_row(rshs_pkg::CMD_TICK,   1'b1, 16'd0,    rshs_pkg::ROT_NONE),
      item_row(rshs_pkg::CMD_MODE,   1'b0, 16'h5A5A, rshs_pkg::ROT_UP),
      item_row(rshs_pkg::CMD_TICK,   1'b0, 16'd0,    rshs_pkg::ROT_NONE),
      item_row(rshs_pkg::CMD_MODE,   1'b1, 16'd0,    rshs_pkg::ROT_NONE),
      // far target, the shorter way is across the wrap point
      item_row(rshs_pkg::CMD_TARGET, 1'b0, 16'd0,    rshs_pkg::ROT_UP),
      item_row(rshs_pkg::CMD_TICK,   1'b1, 16'd0,    rshs_pkg::ROT_NONE),
      // tiny step limit: third step in the first phase trips the failure
      cfg_row(rshs_pkg::CFG_LIMIT, 16'd1),
      checked_row(rshs_pkg::CMD_HOME, 1'b0, 16'hA5A5, rshs_pkg::ROT_DOWN,
                  0, 0, 16'd2726, rshs_pkg::PH_START),
      item_row(rshs_pkg::CMD_TICK,   1'b0, 16'd0,    rshs_pkg::ROT_NONE),
      item_row(rshs_pkg::CMD_TICK,   1'b0, 16'd0,    rshs_pkg::ROT_NONE),
      item_row(rshs_pkg::CMD_TICK,   1'b0, 16'd0,    rshs_pkg::ROT_NONE),
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  1, 1, 16'd2726, rshs_pkg::PH_FAIL1),
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd2726, rshs_pkg::PH_FAIL1),
      // slowest rate: a tick right after restart does nothing
      cfg_row(rshs_pkg::CFG_INTERVAL, 16'hFFFF),
      checked_row(rshs_pkg::CMD_HOME, 1'b1, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd2726, rshs_pkg::PH_START),
      checked_row(rshs_pkg::CMD_TICK, 1'b0, 16'd0, rshs_pkg::ROT_NONE,
                  0, 0, 16'd2726, rshs_pkg::PH_START)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_results_drained();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register set; extremes of the sweep,
    // center, offset and window registers land in one of them
    for (int p = 0; p < RUN_PHASES; p++) begin
      wait_results_drained();
      unique case (p)
        0:       sw = 16'd1;
        1:       sw = 16'hFFFF;
        2:       sw = 16'd2;
        5:       sw = rshs_pkg::pos_t'($urandom_range(100, 6000));
        default: sw = rshs_pkg::pos_t'($urandom_range(3, 64));
      endcase
      ctr = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF :
            (p == 4) ? rshs_pkg::pos_t'($urandom_range(0, 65535))
                     : rshs_pkg::pos_t'($urandom_range(0, sw - 1));
      ivl = (p == 7) ? 16'd4 : rshs_pkg::pos_t'($urandom_range(1, 3));
      lim = (p == 1) ? 16'hFFFF : (p == 3) ? 16'd1 : (p == 6) ? 16'd2
          : rshs_pkg::pos_t'($urandom_range(8, 60));
      off = (p == 0) ? 11'h400 : (p == 1) ? 11'h3FF : 11'($urandom_range(0, 2047));
      win = (p == 7) ? 10'h3FF : (p == 1) ? 10'd0 : 10'($urandom_range(0, 8));
      write_reg(rshs_pkg::CFG_SWEEP,    sw);
      write_reg(rshs_pkg::CFG_CENTER,   ctr);
      write_reg(rshs_pkg::CFG_INTERVAL, ivl);
      write_reg(rshs_pkg::CFG_LIMIT,    lim);
      write_reg(rshs_pkg::CFG_OFFSET,
                {{(rshs_pkg::CfgDataW-rshs_pkg::OffW){off[rshs_pkg::OffW-1]}}, off});
      write_reg(rshs_pkg::CFG_WINDOW,
                {{(rshs_pkg::CfgDataW-rshs_pkg::WinW){1'b0}}, win});

      quiet_sender   = (p == 2 || p == 4 || p == 6);
      quiet_receiver = (p == 2 || p == 5 || p == 6);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender holds back once until the block has caught up
        if (p == 3 && k == 80) wait_results_drained();

        // each seek phase gets a fresh dwell: ticks before the sensor edge
        if (hm_phase != seen_ph) begin
          seen_ph    = hm_phase;
          seek_ticks = 0;
          dwell      = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 6);
        end
        seeking = (hm_phase >= rshs_pkg::PH_SEEK1 && hm_phase <= rshs_pkg::PH_SEEK4);
        roll    = $urandom_range(0, 99);
        if (k == 0)                        it.cmd = rshs_pkg::CMD_HOME;
        else if (roll < (seeking ? 1 : 4)) it.cmd = rshs_pkg::CMD_HOME;
        else if (roll < 12)                it.cmd = rshs_pkg::CMD_TARGET;
        else if (roll < 20)                it.cmd = rshs_pkg::CMD_MODE;
        else                               it.cmd = rshs_pkg::CMD_TICK;

        // sensor follows a plausible magnet pass, with some noise
        unique case (hm_phase)
          rshs_pkg::PH_SEEK1, rshs_pkg::PH_SEEK3: it.hall_down = (seek_ticks >= dwell);
          rshs_pkg::PH_SEEK2, rshs_pkg::PH_SEEK4: it.hall_down = (seek_ticks < dwell);
          default:            it.hall_down = 1'($urandom_range(0, 1));
        endcase
        if ($urandom_range(0, 19) == 0) it.hall_down = !it.hall_down;
        if (it.cmd == rshs_pkg::CMD_TICK) seek_ticks++;

        it.target_position = ($urandom_range(0, 3) == 0)
                           ? rshs_pkg::pos_t'($urandom_range(0, 65535))
                           : rshs_pkg::pos_t'($urandom_range(0, sh_sweep));
        it.rotate_mode     = rshs_pkg::mode_t'($urandom_range(0, 3));
        send_item(it, 1'b0, '0);
      end
    end

    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    wait_results_drained();
    repeat (PIPE_LATENCY + 6) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
